// ===== design/latency_stats_percentile_engine_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the latency statistics engine
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef LATENCY_STATS_PERCENTILE_ENGINE_CORE_ASSERT_SVH
`define LATENCY_STATS_PERCENTILE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define LSP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg
// Types, widths and constants shared by the latency statistics engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lsp_pkg;

  localparam int unsigned SAMPLE_W    = 48;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned MEAN_W      = 56;
  localparam int unsigned VAR_W       = 64;
  localparam int unsigned RATE_W      = 40;
  localparam int unsigned PAYLOAD_W   = 32;
  localparam int unsigned WIDE_W      = 128;
  localparam int unsigned MUL_B_W     = 64;
  localparam int unsigned DEN_W       = 64;
  localparam int unsigned DC_W        = $clog2(WIDE_W + 1);
  localparam int unsigned NUM_RANK    = 6;

  localparam int unsigned MAX_SAMPLES_DEF = 4096;
  localparam int unsigned SAMPLE_BITS_DEF = 48;

  localparam logic [PAYLOAD_W-1:0] PAYLOAD_RESET = 32'd64;
  localparam logic [WIDE_W-1:0]    RATE_NUM      = WIDE_W'(64'd256000000000);
  localparam int unsigned PCT_K0     = 500;
  localparam int unsigned PCT_K1     = 900;
  localparam int unsigned PCT_K2     = 990;
  localparam int unsigned PCT_K3     = 999;
  localparam int unsigned PCT_ROUND  = 500;
  localparam int unsigned PCT_SCALE  = 1000;
  // floor(x / PCT_SCALE) = (x * PCT_RECIP) >> PCT_SHIFT, exact for any x below 2^32
  localparam int unsigned PCT_RECIP  = 1099511628;
  localparam int unsigned PCT_SHIFT  = 40;

  // Post-run arithmetic steps, issued in this order.
  typedef enum logic [3:0] {
    OP_NN, OP_NSQ, OP_SS, OP_VAR, OP_MEAN, OP_RATE,
    OP_PK0, OP_PD0, OP_PK1, OP_PD1, OP_PK2, OP_PD2, OP_PK3, OP_PD3
  } op_e;

  typedef struct packed {
    logic take;
    logic sq_clr;
    logic idx_clr;
    logic idx_inc;
    logic mem_rd;
    logic mul_start;
    logic sq_mode;
    logic div_start;
    logic sq_acc;
    logic op_wr;
    op_e  op;
    logic sel_init;
    logic sel_cnt;
    logic sel_upd;
    logic out_load;
    logic run_clr;
  } lsp_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic mul_done;
    logic div_done;
    logic bit_last;
  } lsp_sts_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   count;
    logic [SAMPLE_W-1:0]  min_ns;
    logic [SAMPLE_W-1:0]  max_ns;
    logic [MEAN_W-1:0]    mean_q8;
    logic [SAMPLE_W-1:0]  p50_ns;
    logic [SAMPLE_W-1:0]  p90_ns;
    logic [SAMPLE_W-1:0]  p99_ns;
    logic [SAMPLE_W-1:0]  p999_ns;
    logic [VAR_W-1:0]     var_ns_sq;
    logic [RATE_W-1:0]    rate_rps;
    logic [PAYLOAD_W-1:0] payload_echo;
    logic                 overflow;
  } lsp_summary_t;

  function automatic logic op_is_div(input op_e op);
    logic r;
    case (op) inside
      OP_VAR, OP_MEAN, OP_RATE: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/lsp_if.sv =====
// ----------------------------------------------------------------------------
// lsp_if
// Valid/ready channels of the latency statistics engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsp_sample_if;
  import lsp_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_ns;
  logic                last;
  modport source (output valid, sample_ns, last, input ready);
  modport sink (input valid, sample_ns, last, output ready);
endinterface

interface lsp_summary_if;
  import lsp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [COUNT_W-1:0]   count;
  logic [SAMPLE_W-1:0]  min_ns;
  logic [SAMPLE_W-1:0]  max_ns;
  logic [MEAN_W-1:0]    mean_q8;
  logic [SAMPLE_W-1:0]  p50_ns;
  logic [SAMPLE_W-1:0]  p90_ns;
  logic [SAMPLE_W-1:0]  p99_ns;
  logic [SAMPLE_W-1:0]  p999_ns;
  logic [VAR_W-1:0]     var_ns_sq;
  logic [RATE_W-1:0]    rate_rps;
  logic [PAYLOAD_W-1:0] payload_echo;
  logic                 overflow;
  modport source (output valid, count, min_ns, max_ns, mean_q8, p50_ns, p90_ns, p99_ns,
                  p999_ns, var_ns_sq, rate_rps, payload_echo, overflow, input ready);
  modport sink (input valid, count, min_ns, max_ns, mean_q8, p50_ns, p90_ns, p99_ns,
                p999_ns, var_ns_sq, rate_rps, payload_echo, overflow, output ready);
endinterface

interface lsp_cfg_if;
  import lsp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PAYLOAD_W-1:0] payload_len;
  modport source (output valid, payload_len, input ready);
  modport sink (input valid, payload_len, output ready);
endinterface

`default_nettype wire

// ===== design/lsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsp_ctrl
// Sequencer: ingest, sum of squares, arithmetic steps, selection passes.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              smp_valid_i,
  input  logic              smp_last_i,
  output logic              smp_ready_o,
  input  logic              sum_ready_i,
  output logic              sum_valid_o,
  input  lsp_pkg::lsp_sts_t sts_i,
  output lsp_pkg::lsp_cmd_t cmd_o
);
  import lsp_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SQ_RD   = 4'd1;
  localparam logic [3:0] S_SQ_GO   = 4'd2;
  localparam logic [3:0] S_SQ_WT   = 4'd3;
  localparam logic [3:0] S_OP_GO   = 4'd4;
  localparam logic [3:0] S_OP_WT   = 4'd5;
  localparam logic [3:0] S_SEL_RUN = 4'd6;
  localparam logic [3:0] S_SEL_DRN = 4'd7;
  localparam logic [3:0] S_SEL_UPD = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0] state_q, state_d;
  op_e        step_q, step_d;
  logic       vld_q, vld_d;
  logic       unit_done_w;

  assign smp_ready_o = (state_q == S_IDLE);
  assign sum_valid_o = vld_q;
  assign unit_done_w = op_is_div(step_q) ? sts_i.div_done : sts_i.mul_done;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    cmd_o     = '0;
    cmd_o.op  = step_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take = smp_valid_i;
        if (smp_valid_i && smp_last_i) begin
          cmd_o.idx_clr = 1'b1;
          cmd_o.sq_clr  = 1'b1;
          state_d       = S_SQ_RD;
        end
      end
      S_SQ_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_SQ_GO;
      end
      S_SQ_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.sq_mode   = 1'b1;
        state_d         = S_SQ_WT;
      end
      S_SQ_WT: begin
        if (sts_i.mul_done) begin
          cmd_o.sq_acc = 1'b1;
          if (sts_i.idx_last) begin
            step_d  = OP_NN;
            state_d = S_OP_GO;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_SQ_RD;
          end
        end
      end
      S_OP_GO: begin
        cmd_o.mul_start = !op_is_div(step_q);
        cmd_o.div_start = op_is_div(step_q);
        state_d         = S_OP_WT;
      end
      S_OP_WT: begin
        if (unit_done_w) begin
          cmd_o.op_wr = 1'b1;
          if (step_q == OP_PD3) begin
            cmd_o.sel_init = 1'b1;
            state_d        = S_SEL_RUN;
          end else begin
            step_d  = op_e'(step_q + 4'd1);
            state_d = S_OP_GO;
          end
        end
      end
      S_SEL_RUN: begin
        cmd_o.mem_rd  = 1'b1;
        cmd_o.sel_cnt = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_SEL_DRN;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_SEL_DRN: begin
        cmd_o.sel_cnt = 1'b1;
        state_d       = S_SEL_UPD;
      end
      S_SEL_UPD: begin
        cmd_o.sel_upd = 1'b1;
        state_d       = sts_i.bit_last ? S_FIN : S_SEL_RUN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!vld_q || sum_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.run_clr  = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    if (vld_q && sum_ready_i) vld_d = 1'b0;
    if (cmd_o.out_load)       vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= OP_NN;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      vld_q   <= vld_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/lsp_dp.sv =====
// ----------------------------------------------------------------------------
// lsp_dp
// Sample store, accumulators, shift-add multiplier, restoring divider and
// bitwise rank selection.
// ----------------------------------------------------------------------------
`default_nettype none
`include "latency_stats_percentile_engine_core_assert.svh"

module lsp_dp #(
  parameter int unsigned MAX_SAMPLES = lsp_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = lsp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lsp_pkg::lsp_cmd_t              cmd_i,
  output lsp_pkg::lsp_sts_t              sts_o,
  input  logic [lsp_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                           cfg_we_i,
  input  logic [lsp_pkg::PAYLOAD_W-1:0]  cfg_data_i,
  output lsp_pkg::lsp_summary_t          sum_o
);
  import lsp_pkg::*;

  localparam int unsigned AW      = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_RAW = SAMPLE_BITS + CNT_W;
  localparam int unsigned SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
  localparam int unsigned BIT_W   = $clog2(SAMPLE_BITS);
  localparam int unsigned PK_W    = CNT_W + 10;

  logic [SAMPLE_BITS-1:0] mem_q [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0] rdata_q;
  logic                   rd_vld_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [SUM_W-1:0]       sum_q;
  logic                   drop_q;
  logic [PAYLOAD_W-1:0]   cfg_q;
  logic [AW-1:0]          idx_q;
  logic [WIDE_W-1:0]      sumsq_q;

  logic [WIDE_W-1:0]      ma_q, mp_q;
  logic [MUL_B_W-1:0]     mb_q;
  logic [WIDE_W-1:0]      dq_q;
  logic [DEN_W-1:0]       dd_q, dr_q;
  logic [DC_W-1:0]        dc_q;

  logic [DEN_W-1:0]       nn_q;
  logic [WIDE_W-1:0]      vnum_q;
  logic [VAR_W-1:0]       var_q;
  logic                   sat_q;
  logic [MEAN_W-1:0]      mean_q;
  logic [RATE_W-1:0]      rate_q;
  logic [PK_W-1:0]        tmp_q;
  logic [CNT_W-1:0]       rank_q [NUM_RANK];
  logic [SAMPLE_BITS-1:0] pv_q   [NUM_RANK];
  logic [CNT_W-1:0]       pc_q   [NUM_RANK];
  logic [BIT_W-1:0]       bit_q;
  lsp_summary_t           out_q;

  logic [SAMPLE_BITS-1:0] x_w;
  logic                   full_w;
  logic [CNT_W-1:0]       n_m1_w;
  logic [WIDE_W-1:0]      mul_a_w;
  logic [MUL_B_W-1:0]     mul_b_w;
  logic [WIDE_W-1:0]      div_n_w;
  logic [DEN_W-1:0]       div_d_w;
  logic [DEN_W:0]         rem_nx_w, rem_sub_w;
  logic                   rem_ge_w;
  logic [SAMPLE_BITS-1:0] mask_w;
  logic [NUM_RANK-1:0]    hit_w;
  logic [WIDE_W-1:0]      pct_w;
  logic [CNT_W-1:0]       clamp_w;

  assign x_w    = SAMPLE_BITS'(sample_i);
  assign full_w = (cnt_q == CNT_W'(MAX_SAMPLES));
  assign n_m1_w = cnt_q - CNT_W'(1);
  assign mask_w = {SAMPLE_BITS{1'b1}} << bit_q;
  // rank index: reciprocal product shifted down
  assign pct_w   = mp_q >> PCT_SHIFT;
  assign clamp_w = (pct_w > WIDE_W'(n_m1_w)) ? n_m1_w : pct_w[CNT_W-1:0];

  assign sts_o.idx_last = (idx_q == n_m1_w[AW-1:0]);
  assign sts_o.mul_done = (mb_q == '0);
  assign sts_o.div_done = (dc_q == '0);
  assign sts_o.bit_last = (bit_q == '0);
  assign sum_o          = out_q;

  always_comb begin
    for (int j = 0; j < NUM_RANK; j++) begin
      hit_w[j] = ((rdata_q ^ pv_q[j]) & mask_w) == '0;
    end
  end

  // operand select for the two iterative units
  always_comb begin
    mul_a_w = '0;
    mul_b_w = '0;
    div_n_w = '0;
    div_d_w = '0;
    unique case (cmd_i.op) inside
      OP_NN: begin
        mul_a_w = WIDE_W'(cnt_q);
        mul_b_w = MUL_B_W'(cnt_q);
      end
      OP_NSQ: begin
        mul_a_w = sumsq_q;
        mul_b_w = MUL_B_W'(cnt_q);
      end
      OP_SS: begin
        mul_a_w = WIDE_W'(sum_q);
        mul_b_w = MUL_B_W'(sum_q);
      end
      OP_PK0: begin
        mul_a_w = WIDE_W'(n_m1_w);
        mul_b_w = MUL_B_W'(PCT_K0);
      end
      OP_PK1: begin
        mul_a_w = WIDE_W'(n_m1_w);
        mul_b_w = MUL_B_W'(PCT_K1);
      end
      OP_PK2: begin
        mul_a_w = WIDE_W'(n_m1_w);
        mul_b_w = MUL_B_W'(PCT_K2);
      end
      OP_PK3: begin
        mul_a_w = WIDE_W'(n_m1_w);
        mul_b_w = MUL_B_W'(PCT_K3);
      end
      OP_VAR: begin
        div_n_w = vnum_q;
        div_d_w = nn_q;
      end
      OP_MEAN: begin
        div_n_w = WIDE_W'(sum_q) << 8;
        div_d_w = DEN_W'(cnt_q);
      end
      OP_RATE: begin
        div_n_w = RATE_NUM;
        div_d_w = DEN_W'(mean_q);
      end
      OP_PD0, OP_PD1, OP_PD2, OP_PD3: begin
        mul_a_w = WIDE_W'(tmp_q) + WIDE_W'(PCT_ROUND);
        mul_b_w = MUL_B_W'(PCT_RECIP);
      end
      default: ;
    endcase
  end

  assign rem_nx_w  = {dr_q, dq_q[WIDE_W-1]};
  assign rem_ge_w  = rem_nx_w >= {1'b0, dd_q};
  assign rem_sub_w = rem_nx_w - {1'b0, dd_q};

  // sample store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !full_w) mem_q[cnt_q[AW-1:0]] <= x_w;
    if (cmd_i.mem_rd)          rdata_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      drop_q   <= 1'b0;
      cfg_q    <= PAYLOAD_RESET;
      rd_vld_q <= 1'b0;
      mb_q     <= '0;
      dc_q     <= '0;
    end else begin
      rd_vld_q <= cmd_i.mem_rd;
      if (cfg_we_i) cfg_q <= cfg_data_i;
      if (cmd_i.run_clr) begin
        cnt_q  <= '0;
        sum_q  <= '0;
        drop_q <= 1'b0;
      end else if (cmd_i.take) begin
        if (full_w) begin
          drop_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
          sum_q <= sum_q + SUM_W'(x_w);
        end
      end
      if (cmd_i.mul_start) begin
        mb_q <= cmd_i.sq_mode ? MUL_B_W'(rdata_q) : mul_b_w;
      end else if (mb_q != '0) begin
        mb_q <= mb_q >> 1;
      end
      if (cmd_i.div_start) begin
        dc_q <= DC_W'(WIDE_W);
      end else if (dc_q != '0) begin
        dc_q <= dc_q - DC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // shift-add multiplier, one multiplier bit per cycle
    if (cmd_i.mul_start) begin
      ma_q <= cmd_i.sq_mode ? WIDE_W'(rdata_q) : mul_a_w;
      mp_q <= '0;
    end else if (mb_q != '0) begin
      if (mb_q[0]) mp_q <= mp_q + ma_q;
      ma_q <= ma_q << 1;
    end
    // restoring divider, one quotient bit per cycle
    if (cmd_i.div_start) begin
      dq_q <= div_n_w;
      dd_q <= div_d_w;
      dr_q <= '0;
    end else if (dc_q != '0) begin
      dr_q <= rem_ge_w ? rem_sub_w[DEN_W-1:0] : rem_nx_w[DEN_W-1:0];
      dq_q <= {dq_q[WIDE_W-2:0], rem_ge_w};
    end

    if (cmd_i.sq_clr) sumsq_q <= '0;
    if (cmd_i.sq_acc) sumsq_q <= sumsq_q + mp_q;

    if (cmd_i.idx_clr || cmd_i.sel_init || cmd_i.sel_upd) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + AW'(1);
    end

    if (cmd_i.op_wr) begin
      unique case (cmd_i.op) inside
        OP_NN:   nn_q   <= mp_q[DEN_W-1:0];
        OP_NSQ:  vnum_q <= mp_q;
        OP_SS:   vnum_q <= vnum_q - mp_q;
        OP_VAR: begin
          var_q <= dq_q[VAR_W-1:0];
          sat_q <= |dq_q[WIDE_W-1:VAR_W];
        end
        OP_MEAN: mean_q <= dq_q[MEAN_W-1:0];
        OP_RATE: rate_q <= (mean_q == '0) ? '0 : dq_q[RATE_W-1:0];
        OP_PK0, OP_PK1, OP_PK2, OP_PK3: tmp_q <= mp_q[PK_W-1:0];
        OP_PD0:  rank_q[1] <= clamp_w;
        OP_PD1:  rank_q[2] <= clamp_w;
        OP_PD2:  rank_q[3] <= clamp_w;
        OP_PD3:  rank_q[4] <= clamp_w;
        default: ;
      endcase
    end

    // rank selection, one sample bit per pass, MSB first
    if (cmd_i.sel_init) begin
      for (int j = 0; j < NUM_RANK; j++) begin
        pv_q[j] <= '0;
        pc_q[j] <= '0;
      end
      rank_q[0]          <= '0;
      rank_q[NUM_RANK-1] <= n_m1_w;
      bit_q              <= BIT_W'(SAMPLE_BITS - 1);
    end else if (cmd_i.sel_upd) begin
      for (int j = 0; j < NUM_RANK; j++) begin
        pc_q[j] <= '0;
        if (pc_q[j] <= rank_q[j]) begin
          rank_q[j]       <= rank_q[j] - pc_q[j];
          pv_q[j][bit_q]  <= 1'b1;
        end
      end
      bit_q <= bit_q - BIT_W'(1);
    end else if (cmd_i.sel_cnt && rd_vld_q) begin
      for (int j = 0; j < NUM_RANK; j++) begin
        if (hit_w[j]) pc_q[j] <= pc_q[j] + CNT_W'(1);
      end
    end

    if (cmd_i.out_load) begin
      out_q.count        <= COUNT_W'(cnt_q);
      out_q.min_ns       <= SAMPLE_W'(pv_q[0]);
      out_q.max_ns       <= SAMPLE_W'(pv_q[NUM_RANK-1]);
      out_q.mean_q8      <= mean_q;
      out_q.p50_ns       <= SAMPLE_W'(pv_q[1]);
      out_q.p90_ns       <= SAMPLE_W'(pv_q[2]);
      out_q.p99_ns       <= SAMPLE_W'(pv_q[3]);
      out_q.p999_ns      <= SAMPLE_W'(pv_q[4]);
      out_q.var_ns_sq    <= sat_q ? {VAR_W{1'b1}} : var_q;
      out_q.rate_rps     <= rate_q;
      out_q.payload_echo <= cfg_q;
      out_q.overflow     <= drop_q | sat_q;
    end
  end

  `LSP_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_SAMPLES), "sample count past capacity")
  `LSP_ASSERT_NEXT(a_run_clr, cmd_i.run_clr, (cnt_q == '0) && !drop_q, "run state not cleared")
  `LSP_ASSERT_IMPL(a_out_nonempty, cmd_i.out_load, cnt_q != '0, "summary of an empty run")

endmodule

`default_nettype wire

// ===== design/latency_stats_percentile_engine_core.sv =====
// Samples are taken one per cycle while idle. After the last sample the engine scans
// the kept samples for the sum of squares, runs three divisions and eleven shift-add
// multiplies, then makes one selection pass over the store per sample bit, and only
// then loads the summary word.
// Throughput: one sample per cycle between runs; no sample is taken during the summary pass.
// Reset: clears counters, the sample sum and handshake state; the sample store is not cleared.
// ----------------------------------------------------------------------------
// latency_stats_percentile_engine_core
// Collects latency samples into a store and, on the last word of a run,
// emits count, min, max, mean, P50/P90/P99/P99.9, variance and request rate.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_stats_percentile_engine_core #(
  parameter int unsigned MAX_SAMPLES = lsp_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = lsp_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lsp_sample_if.sink    smp_i,
  lsp_summary_if.source sum_o,
  lsp_cfg_if.sink       cfg_i
);
  import lsp_pkg::*;

  lsp_cmd_t     cmd;
  lsp_sts_t     sts;
  lsp_summary_t summary;

  // The register port never stalls; user writes must land only between runs, unchecked.
  assign cfg_i.ready = 1'b1;

  // Controller: sequences ingest, the sum-of-squares scan, the arithmetic
  // steps and the per-bit selection scans, then hands off the summary word.
  lsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_valid_i (smp_i.valid),
    .smp_last_i  (smp_i.last),
    .smp_ready_o (smp_i.ready),
    .sum_ready_i (sum_o.ready),
    .sum_valid_o (sum_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: store, accumulators, iterative multiply/divide, rank selection.
  lsp_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .sample_i   (smp_i.sample_ns),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.payload_len),
    .sum_o      (summary)
  );

  // Drive the summary word from the output register.
  assign sum_o.count        = summary.count;
  assign sum_o.min_ns       = summary.min_ns;
  assign sum_o.max_ns       = summary.max_ns;
  assign sum_o.mean_q8      = summary.mean_q8;
  assign sum_o.p50_ns       = summary.p50_ns;
  assign sum_o.p90_ns       = summary.p90_ns;
  assign sum_o.p99_ns       = summary.p99_ns;
  assign sum_o.p999_ns      = summary.p999_ns;
  assign sum_o.var_ns_sq    = summary.var_ns_sq;
  assign sum_o.rate_rps     = summary.rate_rps;
  assign sum_o.payload_echo = summary.payload_echo;
  assign sum_o.overflow     = summary.overflow;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency statistics engine testbench
// Streams latency sample runs into the engine under bursty traffic and a
// stalling summary receiver, predicts every summary in a scoreboard and
// compares it field by field with what the engine returns.
// ----------------------------------------------------------------------------

class lsp_summary_scoreboard;
  localparam int unsigned STORE_DEPTH = 4096;

  lsp_pkg::lsp_summary_t summary_q[$];
  bit [47:0]             run_samples[$];
  bit [63:0]             run_sum;
  bit                    run_dropped;
  bit [31:0]             payload_len;
  int unsigned           mismatches;
  int unsigned           errors;

  function new();
    payload_len   = lsp_pkg::PAYLOAD_RESET;
    run_sum       = '0;
    run_dropped   = 1'b0;
    mismatches    = 0;
    errors        = 0;
  endfunction

  function bit [47:0] pick_rank(input bit [47:0] sorted[$], input int unsigned k);
    int unsigned n;
    int unsigned idx;
    n   = sorted.size();
    idx = (k * (n - 1) + lsp_pkg::PCT_ROUND) / lsp_pkg::PCT_SCALE;
    if (idx > n - 1) idx = n - 1;
    return sorted[idx];
  endfunction

  // Note one accepted sample word; a last word closes the run and queues a summary.
  function void note_sample(bit [47:0] sample, bit last);
    bit [47:0]             sorted[$];
    bit [127:0]            sumsq;
    bit [127:0]            mean;
    bit [127:0]            num;
    bit [127:0]            quot;
    lsp_pkg::lsp_summary_t sm;
    int unsigned           n;
    if (run_samples.size() < STORE_DEPTH) begin
      run_samples.insert(run_samples.size(), sample);
      run_sum += sample;
    end else begin
      run_dropped = 1'b1;
    end
    if (!last) return;
    sorted = run_samples;
    sorted.sort();
    n     = sorted.size();
    sumsq = '0;
    foreach (sorted[i]) sumsq += 128'(sorted[i]) * 128'(sorted[i]);
    mean = (128'(run_sum) << 8) / 128'(n);
    num  = 128'(n) * sumsq - 128'(run_sum) * 128'(run_sum);
    quot = num / (128'(n) * 128'(n));
    sm.count        = 13'(n);
    sm.min_ns       = sorted[0];
    sm.max_ns       = sorted[n - 1];
    sm.mean_q8      = mean[55:0];
    sm.p50_ns       = pick_rank(sorted, lsp_pkg::PCT_K0);
    sm.p90_ns       = pick_rank(sorted, lsp_pkg::PCT_K1);
    sm.p99_ns       = pick_rank(sorted, lsp_pkg::PCT_K2);
    sm.p999_ns      = pick_rank(sorted, lsp_pkg::PCT_K3);
    sm.var_ns_sq    = (quot[127:64] != 0) ? '1 : quot[63:0];
    sm.rate_rps     = (mean[55:0] == 0) ? '0 : 40'(lsp_pkg::RATE_NUM / 128'(mean[55:0]));
    sm.payload_echo = payload_len;
    sm.overflow     = run_dropped || (quot[127:64] != 0);
    summary_q.insert(summary_q.size(), sm);
    run_samples.delete();
    run_sum     = '0;
    run_dropped = 1'b0;
  endfunction

  function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, act_v);
    end
  endfunction

  // Check one accepted summary word against the oldest prediction.
  function void check(lsp_pkg::lsp_summary_t got);
    lsp_pkg::lsp_summary_t ex;
    if (summary_q.size() == 0) begin
      errors++;
      $display("%0t unexpected summary word, count %0d", $realtime, got.count);
      return;
    end
    ex = summary_q.pop_front();
    cmp_field("count",        64'(ex.count),        64'(got.count));
    cmp_field("min_ns",       64'(ex.min_ns),       64'(got.min_ns));
    cmp_field("max_ns",       64'(ex.max_ns),       64'(got.max_ns));
    cmp_field("mean_q8",      64'(ex.mean_q8),      64'(got.mean_q8));
    cmp_field("p50_ns",       64'(ex.p50_ns),       64'(got.p50_ns));
    cmp_field("p90_ns",       64'(ex.p90_ns),       64'(got.p90_ns));
    cmp_field("p99_ns",       64'(ex.p99_ns),       64'(got.p99_ns));
    cmp_field("p999_ns",      64'(ex.p999_ns),      64'(got.p999_ns));
    cmp_field("var_ns_sq",    ex.var_ns_sq,         got.var_ns_sq);
    cmp_field("rate_rps",     64'(ex.rate_rps),     64'(got.rate_rps));
    cmp_field("payload_echo", 64'(ex.payload_echo), 64'(got.payload_echo));
    cmp_field("overflow",     64'(ex.overflow),     64'(got.overflow));
  endfunction
endclass

module testbench;
  import lsp_pkg::*;

  localparam logic [47:0] SAMPLE_MAX = '1;

  logic clk_i;
  logic rst_ni;

  lsp_sample_if  smp();
  lsp_summary_if sum();
  lsp_cfg_if     cfg();

  latency_stats_percentile_engine_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .smp_i (smp),
    .sum_o (sum),
    .cfg_i (cfg)
  );

  lsp_summary_scoreboard summary_sb = new();

  // Sender burst state and pressure requests.
  int unsigned burst_left;
  int unsigned word_count;
  bit          gap_enable;
  bit          hold_req;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Drive one sample word and hold it until the engine takes it; then
  // drop valid for a random gap when the current burst runs out and gaps are enabled.
  task automatic send_word(input logic [47:0] sample, input logic last);
    smp.valid     <= 1'b1;
    smp.sample_ns <= sample;
    smp.last      <= last;
    do @(posedge clk_i); while (!smp.ready);
    summary_sb.note_sample(sample, last);
    word_count++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if (gap_enable) begin
        smp.valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  endtask

  // Park the sample channel, wait for every pending summary and let the
  // engine settle before touching the register.
  task automatic drain();
    smp.valid <= 1'b0;
    @(posedge clk_i);
    while (summary_sb.summary_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_payload(input logic [31:0] value);
    cfg.valid       <= 1'b1;
    cfg.payload_len <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    summary_sb.payload_len = value;
    @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_sample();
    logic [47:0] v;
    case ($urandom_range(0, 6))
      0: v = '0;
      1: v = SAMPLE_MAX;
      2: v = 48'({$urandom, $urandom});
      3: v = 48'($urandom_range(0, 1000));
      4: v = 48'($urandom_range(0, 1 << 20));
      5: v = 48'({$urandom, $urandom} >> $urandom_range(0, 47));
      default: v = 48'($urandom_range(5000, 200000));
    endcase
    return v;
  endfunction

  // Send a whole run; mostly short runs keep the summary pass cheap.
  task automatic send_run(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_word(rand_sample(), i == len - 1);
  endtask

  // Summary receiver: stall on its own changing pattern, and serve a long
  // hold-off when the sender asks for one.
  initial begin
    int unsigned mode;
    int unsigned hold_cnt;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(50, 300)) begin
        @(posedge clk_i);
        if (hold_req) begin
          sum.ready <= 1'b0;
          hold_cnt = 0;
          while (hold_cnt < 6000) begin
            @(posedge clk_i);
            hold_cnt++;
          end
          hold_req = 1'b0;
        end
        case (mode)
          0: sum.ready <= 1'b1;
          1: sum.ready <= ($urandom_range(0, 3) != 0);
          2: sum.ready <= ($urandom_range(0, 3) == 0);
          default: sum.ready <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // Check every accepted summary word.
  always @(posedge clk_i) begin
    lsp_summary_t got;
    if (rst_ni && sum.valid && sum.ready) begin
      got.count        = sum.count;
      got.min_ns       = sum.min_ns;
      got.max_ns       = sum.max_ns;
      got.mean_q8      = sum.mean_q8;
      got.p50_ns       = sum.p50_ns;
      got.p90_ns       = sum.p90_ns;
      got.p99_ns       = sum.p99_ns;
      got.p999_ns      = sum.p999_ns;
      got.var_ns_sq    = sum.var_ns_sq;
      got.rate_rps     = sum.rate_rps;
      got.payload_echo = sum.payload_echo;
      got.overflow     = sum.overflow;
      summary_sb.check(got);
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    smp.valid       = 1'b0;
    smp.sample_ns   = '0;
    smp.last        = 1'b0;
    sum.ready       = 1'b0;
    cfg.valid       = 1'b0;
    cfg.payload_len = '0;
    rst_ni          = 1'b0;
    burst_left      = 1;
    word_count      = 0;
    gap_enable      = 1'b1;
    hold_req        = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset payload, then single-sample runs at both extremes
    // (zero mean gives zero rate), and a wide spread that saturates variance.
    send_word('0, 1'b1);
    send_word(SAMPLE_MAX, 1'b1);
    send_word('0, 1'b0);
    send_word(SAMPLE_MAX, 1'b1);
    drain();
    write_payload(32'd4);
    for (int i = 0; i < 10; i++) send_word(48'(i * 37 + 1), i == 9);
    send_word(48'hAAAA_AAAA_AAAA, 1'b0);
    send_word(48'h5555_5555_5555, 1'b1);
    drain();
    write_payload(32'hFFFF_FFFF);
    send_word(48'd1000, 1'b0);
    send_word(48'd1000, 1'b0);
    send_word(48'd1001, 1'b1);
    drain();
    write_payload(32'd0);

    // Store full: overfill one run so the trailing words are dropped,
    // the last of them closing the run. Small values keep it fast.
    gap_enable = 1'b0;
    for (int i = 0; i < 4098; i++) send_word(48'($urandom_range(0, 15)), i == 4097);
    drain();
    write_payload(PAYLOAD_RESET);

    // Random runs with a register change now and then.
    gap_enable = 1'b1;
    word_count = 0;
    while (word_count < 1200) begin
      if (word_count > 300 && word_count < 340) hold_req = 1'b1;
      gap_enable = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 15) == 0) send_run($urandom_range(20, 64));
      else send_run($urandom_range(1, 8));
      if ($urandom_range(0, 30) == 0) begin
        drain();
        write_payload($urandom_range(0, 7) == 0 ? 32'hFFFF_FFFF : $urandom);
      end
    end

    // Wait out the last summaries, then let the engine settle.
    drain();
    repeat (2000) @(posedge clk_i);
    if (summary_sb.mismatches == 0 && summary_sb.errors == 0 &&
        summary_sb.summary_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
